### rtl/hfd_pkg.sv
// Shared types, constants and the glyph table of the framed ASCII Huffman decoder.
// Used by hfd_lehmer, hfd_walker and the top level; depends on nothing.
package hfd_pkg;

  localparam int unsigned NSYM           = 7;
  localparam int unsigned ROOT_NODE      = 12;
  localparam int unsigned HDR_TREE_START = 14;
  localparam int unsigned HDR_DONE       = 20;
  localparam int unsigned TREE_NODES     = 6;
  localparam int unsigned LINE_WIDTH     = 80;
  localparam int unsigned LINE_COUNT     = 22;
  localparam int unsigned PERM_DEPTH     = NSYM * NSYM;
  localparam int unsigned PERM_AW        = $clog2(PERM_DEPTH);
  localparam int unsigned CODE_W         = 16;
  localparam int unsigned CODE_CW        = $clog2(CODE_W);

  typedef struct packed {
    logic [7:0] glyph_code;
    logic [2:0] glyph_index;
    logic       line_end;
    logic       frame_end;
    logic       last;
  } res_t;

  typedef struct packed {
    logic               we;
    logic [PERM_AW-1:0] addr;
    logic [2:0]         data;
  } ram_wr_t;

  typedef struct packed {
    logic busy;
    logic frame_done;
  } walk_stat_t;

  function automatic logic [7:0] glyph_char(input logic [2:0] sym);
    logic [7:0] c;
    case (sym)
      3'd0:    c = 8'h20;  // ' '
      3'd1:    c = 8'h2C;  // ','
      3'd2:    c = 8'h28;  // '('
      3'd3:    c = 8'h53;  // 'S'
      3'd4:    c = 8'h23;  // '#'
      3'd5:    c = 8'h67;  // 'g'
      3'd6:    c = 8'h40;  // '@'
      default: c = 8'h20;
    endcase
    return c;
  endfunction

endpackage

### rtl/hfd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Standalone; no package needed.
module hfd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/hfd_lehmer.sv
// Decodes one 16-bit Lehmer code into a row of the permutation table.
// Bit-serial restoring division by each radix 7..1; uses hfd_pkg.
module hfd_lehmer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [15:0]          code_i,
  input  logic [2:0]           row_i,
  output logic                 busy_o,
  output hfd_pkg::ram_wr_t     wr_o
);

  logic                             busy_q, busy_d;
  logic [hfd_pkg::CODE_W-1:0]       code_q, code_d;
  logic [2:0]                       rem_q, rem_d;
  logic [hfd_pkg::CODE_CW-1:0]      cnt_q, cnt_d;
  logic [2:0]                       radix_q, radix_d;
  logic [2:0]                       digit_q, digit_d;
  logic [2:0]                       row_q, row_d;
  logic [2:0]                       pool_q [hfd_pkg::NSYM];
  logic [2:0]                       pool_d [hfd_pkg::NSYM];

  logic [3:0]                       trial;
  logic                             ge;
  logic [2:0]                       rem_n;
  logic                             digit_done;
  logic [hfd_pkg::PERM_AW-1:0]      row_base;

  // One quotient bit per cycle; the remainder stays below the radix.
  assign trial      = {rem_q, code_q[hfd_pkg::CODE_W-1]};
  assign ge         = trial >= {1'b0, radix_q};
  assign rem_n      = ge ? 3'(trial - {1'b0, radix_q}) : trial[2:0];
  assign digit_done = busy_q && (cnt_q == hfd_pkg::CODE_CW'(hfd_pkg::CODE_W - 1));
  assign row_base   = {row_q, 3'b000} - hfd_pkg::PERM_AW'(row_q);

  always_comb begin
    busy_d  = busy_q;
    code_d  = code_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    radix_d = radix_q;
    digit_d = digit_q;
    row_d   = row_q;
    pool_d  = pool_q;
    if (start_i) begin
      busy_d  = 1'b1;
      code_d  = code_i;
      rem_d   = '0;
      cnt_d   = '0;
      radix_d = 3'(hfd_pkg::NSYM);
      digit_d = '0;
      row_d   = row_i;
      for (int i = 0; i < hfd_pkg::NSYM; i++) begin
        pool_d[i] = 3'(i);
      end
    end else if (busy_q) begin
      code_d = {code_q[hfd_pkg::CODE_W-2:0], ge};
      if (digit_done) begin
        rem_d   = '0;
        cnt_d   = '0;
        radix_d = radix_q - 3'd1;
        digit_d = digit_q + 3'd1;
        for (int j = 0; j < hfd_pkg::NSYM - 1; j++) begin
          pool_d[j] = (3'(j) >= rem_n) ? pool_q[j+1] : pool_q[j];
        end
        if (digit_q == 3'(hfd_pkg::NSYM - 1)) begin
          busy_d = 1'b0;
        end
      end else begin
        rem_d = rem_n;
        cnt_d = cnt_q + hfd_pkg::CODE_CW'(1);
      end
    end
  end

  always_comb begin
    wr_o.we   = digit_done;
    wr_o.addr = row_base + hfd_pkg::PERM_AW'(digit_q);
    wr_o.data = pool_q[rem_n];
  end

  assign busy_o = busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      cnt_q   <= '0;
      radix_q <= 3'(hfd_pkg::NSYM);
      digit_q <= '0;
    end else begin
      busy_q  <= busy_d;
      cnt_q   <= cnt_d;
      radix_q <= radix_d;
      digit_q <= digit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q <= code_d;
    rem_q  <= rem_d;
    row_q  <= row_d;
    pool_q <= pool_d;
  end

endmodule

### rtl/hfd_walker.sv
// Walks the Huffman tree one stream bit per cycle, pausing at each leaf lookup and on output stalls;
// remaps leaves and drives the output. Holds one result back so the last glyph of a byte can be marked; uses hfd_pkg.
module hfd_walker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [7:0]                    byte_i,
  input  logic [7:0]                    children_i [hfd_pkg::TREE_NODES],
  input  logic [2:0]                    rdata_i,
  output logic [hfd_pkg::PERM_AW-1:0]   raddr_o,
  output hfd_pkg::walk_stat_t           stat_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output hfd_pkg::res_t                 out_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WALK  = 2'd1;
  localparam logic [1:0] ST_LOOK  = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  logic [1:0]                  state_q, state_d;
  logic [7:0]                  sh_q, sh_d;
  logic [3:0]                  cnt_q, cnt_d;
  logic [3:0]                  node_q, node_d;
  logic [2:0]                  prev_q, prev_d;
  logic [7:0]                  col_q, col_d;
  logic [7:0]                  line_q, line_d;
  logic [hfd_pkg::PERM_AW-1:0] raddr_q, raddr_d;
  logic                        hold_valid_q, hold_valid_d;
  hfd_pkg::res_t               hold_q, hold_d;
  logic                        out_valid_q, out_valid_d;
  hfd_pkg::res_t               out_q, out_d;

  logic [3:0]                  node_idx;
  logic [2:0]                  slot;
  logic [7:0]                  entry;
  logic [3:0]                  child;
  logic [hfd_pkg::PERM_AW-1:0] leaf_addr;
  logic                        can_load;
  logic [8:0]                  col_inc;
  logic [8:0]                  line_inc;
  logic                        le;
  logic                        fe;
  hfd_pkg::res_t               res;
  logic                        frame_done;

  assign node_idx  = (node_q < 4'(hfd_pkg::NSYM) || node_q > 4'(hfd_pkg::ROOT_NODE))
                     ? 4'(hfd_pkg::ROOT_NODE) : node_q;
  assign slot      = 3'(node_idx - 4'(hfd_pkg::NSYM));
  assign entry     = children_i[slot];
  assign child     = sh_q[7] ? entry[3:0] : entry[7:4];
  assign leaf_addr = {prev_q, 3'b000} - hfd_pkg::PERM_AW'(prev_q)
                     + hfd_pkg::PERM_AW'(child);
  // The read address is held through the lookup so the registered data stays put.
  assign raddr_o   = (state_q == ST_WALK) ? leaf_addr : raddr_q;
  assign can_load  = !out_valid_q || !out_stall_i;

  assign col_inc  = {1'b0, col_q} + 9'd1;
  assign line_inc = {1'b0, line_q} + 9'd1;
  assign le       = col_inc >= 9'(hfd_pkg::LINE_WIDTH);
  assign fe       = le && (line_inc >= 9'(hfd_pkg::LINE_COUNT));

  always_comb begin
    res.glyph_code  = hfd_pkg::glyph_char(rdata_i);
    res.glyph_index = rdata_i;
    res.line_end    = le;
    res.frame_end   = fe;
    res.last        = 1'b0;
  end

  always_comb begin
    state_d      = state_q;
    sh_d         = sh_q;
    cnt_d        = cnt_q;
    node_d       = node_q;
    prev_d       = prev_q;
    col_d        = col_q;
    line_d       = line_q;
    raddr_d      = raddr_q;
    hold_valid_d = hold_valid_q;
    hold_d       = hold_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    frame_done   = 1'b0;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          sh_d    = byte_i;
          cnt_d   = '0;
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        sh_d  = {sh_q[6:0], 1'b0};
        cnt_d = cnt_q + 4'd1;
        if (child < 4'(hfd_pkg::NSYM)) begin
          raddr_d = leaf_addr;
          state_d = ST_LOOK;
        end else begin
          node_d = (child <= 4'(hfd_pkg::ROOT_NODE)) ? child : 4'(hfd_pkg::ROOT_NODE);
          if (cnt_q == 4'd7) begin
            state_d = ST_FLUSH;
          end
        end
      end
      ST_LOOK: begin
        if (!hold_valid_q || can_load) begin
          if (hold_valid_q) begin
            out_d       = hold_q;
            out_valid_d = 1'b1;
          end
          hold_d       = res;
          hold_valid_d = 1'b1;
          prev_d       = rdata_i;
          node_d       = 4'(hfd_pkg::ROOT_NODE);
          col_d        = le ? 8'd0 : col_inc[7:0];
          line_d       = le ? line_inc[7:0] : line_q;
          if (fe) begin
            // End of frame: the rest of this byte is dropped.
            prev_d     = '0;
            col_d      = '0;
            line_d     = '0;
            frame_done = 1'b1;
            state_d    = ST_FLUSH;
          end else if (cnt_q == 4'd8) begin
            state_d = ST_FLUSH;
          end else begin
            state_d = ST_WALK;
          end
        end
      end
      ST_FLUSH: begin
        if (!hold_valid_q) begin
          state_d = ST_IDLE;
        end else if (can_load) begin
          out_d        = hold_q;
          out_d.last   = 1'b1;
          out_valid_d  = 1'b1;
          hold_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    stat_o.busy       = state_q != ST_IDLE;
    stat_o.frame_done = frame_done;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      node_q       <= 4'(hfd_pkg::ROOT_NODE);
      prev_q       <= '0;
      col_q        <= '0;
      line_q       <= '0;
      raddr_q      <= '0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      node_q       <= node_d;
      prev_q       <= prev_d;
      col_q        <= col_d;
      line_q       <= line_d;
      raddr_q      <= raddr_d;
      hold_valid_q <= hold_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q   <= sh_d;
    hold_q <= hold_d;
    out_q  <= out_d;
  end

endmodule

### rtl/ascii_frame_huffman_decoder.sv
// Each odd Lehmer header byte keeps the input stalled while the row decoder divides the
// 16-bit code bit-serially, one digit per radix. Each bitstream byte keeps the input stalled
// until it has been walked, so no new byte is taken before the last one is done; the walk
// goes one bit per cycle with a registered permutation RAM read per leaf, and output stalls hold it.
// Reset is asynchronous, active low; it clears all control state. The permutation table and
// the tree are undefined until the frame header writes them.
module ascii_frame_huffman_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] stream_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] glyph_code_o,
  output logic [2:0] glyph_index_o,
  output logic       line_end_o,
  output logic       frame_end_o,
  output logic       last_o
);

  logic [4:0]                  hdr_q, hdr_d;
  logic [7:0]                  high_q, high_d;
  logic [7:0]                  children_q [hfd_pkg::TREE_NODES];
  logic [7:0]                  children_d [hfd_pkg::TREE_NODES];

  logic                        accept;
  logic                        leh_start;
  logic                        leh_busy;
  logic                        walk_start;
  hfd_pkg::ram_wr_t            wr;
  hfd_pkg::walk_stat_t         stat;
  hfd_pkg::res_t               res;
  logic [hfd_pkg::PERM_AW-1:0] raddr;
  logic [2:0]                  rdata;
  logic [2:0]                  slot;

  assign in_stall_o = leh_busy || stat.busy;
  assign accept     = in_valid_i && !in_stall_o;
  assign slot       = 3'(hdr_q - 5'(hfd_pkg::HDR_TREE_START));
  assign leh_start  = accept && (hdr_q < 5'(hfd_pkg::HDR_TREE_START)) && hdr_q[0];
  assign walk_start = accept && (hdr_q >= 5'(hfd_pkg::HDR_DONE));

  always_comb begin
    hdr_d      = hdr_q;
    high_d     = high_q;
    children_d = children_q;
    if (stat.frame_done) begin
      hdr_d = '0;
    end else if (accept && hdr_q < 5'(hfd_pkg::HDR_DONE)) begin
      hdr_d = hdr_q + 5'd1;
      if (hdr_q < 5'(hfd_pkg::HDR_TREE_START)) begin
        if (!hdr_q[0]) begin
          high_d = stream_byte_i;
        end
      end else begin
        children_d[slot] = stream_byte_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q  <= '0;
      high_q <= '0;
    end else begin
      hdr_q  <= hdr_d;
      high_q <= high_d;
    end
  end

  always_ff @(posedge clk_i) begin
    children_q <= children_d;
  end

  hfd_lehmer u_lehmer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (leh_start),
    .code_i  ({high_q, stream_byte_i}),
    .row_i   (hdr_q[3:1]),
    .busy_o  (leh_busy),
    .wr_o    (wr)
  );

  hfd_ram #(
    .WIDTH (3),
    .DEPTH (hfd_pkg::PERM_DEPTH)
  ) u_perm_ram (
    .clk_i   (clk_i),
    .we_i    (wr.we),
    .waddr_i (wr.addr),
    .wdata_i (wr.data),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  hfd_walker u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (walk_start),
    .byte_i      (stream_byte_i),
    .children_i  (children_q),
    .rdata_i     (rdata),
    .raddr_o     (raddr),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (res)
  );

  assign glyph_code_o  = res.glyph_code;
  assign glyph_index_o = res.glyph_index;
  assign line_end_o    = res.line_end;
  assign frame_end_o   = res.frame_end;
  assign last_o        = res.last;

endmodule

### rtl/hfd_checker.sv
// Port-level assertions for the framed ASCII Huffman decoder, bound to the top level.
// Depends on ascii_frame_huffman_decoder only through the bind below.
module hfd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] glyph_code_o,
  input logic [2:0] glyph_index_o,
  input logic       line_end_o,
  input logic       frame_end_o,
  input logic       last_o
);

  // A stalled result beat stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(glyph_code_o)
      && $stable(glyph_index_o) && $stable(line_end_o) && $stable(frame_end_o)
      && $stable(last_o))
    else $error("result beat changed while stalled");

  // The frame end closes a line and is the final beat of its byte.
  a_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o |-> line_end_o && last_o)
    else $error("frame end without line end or last");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> glyph_index_o != 3'd7)
    else $error("glyph index out of range");

  // The character always matches the index it came from.
  a_code_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (glyph_index_o == 3'd0 && glyph_code_o == 8'h20) ||
      (glyph_index_o == 3'd1 && glyph_code_o == 8'h2C) ||
      (glyph_index_o == 3'd2 && glyph_code_o == 8'h28) ||
      (glyph_index_o == 3'd3 && glyph_code_o == 8'h53) ||
      (glyph_index_o == 3'd4 && glyph_code_o == 8'h23) ||
      (glyph_index_o == 3'd5 && glyph_code_o == 8'h67) ||
      (glyph_index_o == 3'd6 && glyph_code_o == 8'h40))
    else $error("glyph code does not match glyph index");

endmodule

bind ascii_frame_huffman_decoder hfd_checker u_hfd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .glyph_code_o  (glyph_code_o),
  .glyph_index_o (glyph_index_o),
  .line_end_o    (line_end_o),
  .frame_end_o   (frame_end_o),
  .last_o        (last_o)
);
